// ===== rtl/swtd_pkg.sv =====
`default_nettype none

package swtd_pkg;

    localparam int POS_W       = 32;
    localparam int RANGE_W     = 31;
    localparam int SEC_W       = 23;
    localparam int TILE_W      = 24;
    localparam int MAX_RESULTS = 32;
    localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

    localparam logic [TILE_W-1:0] TILE_MAX = 24'h7FFFFF;
    localparam logic [TILE_W-1:0] TILE_MIN = 24'h800000;

    typedef logic signed [TILE_W-1:0] tile_t;

    typedef enum logic [0:0] {
        CFG_REACH     = 1'b0,
        CFG_TILE_EDGE = 1'b1
    } cfg_index_t;

    typedef enum logic {
        ACT_UNLOAD = 1'b0,
        ACT_LOAD   = 1'b1
    } action_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

`default_nettype wire

// ===== rtl/swtd_div.sv =====
`default_nettype none

module swtd_div #(
    parameter int MAG_W = 24
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [MAG_W-1:0]           dividend,
    input  logic [swtd_pkg::SEC_W-1:0] divisor,
    output swtd_pkg::div_status_t      status,
    output logic [MAG_W-1:0]           quotient,
    output logic                       rem_nz
);
    import swtd_pkg::*;

    localparam int CNT_W = $clog2(MAG_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [SEC_W-1:0] rem_reg;
    logic [SEC_W-1:0] div_reg;
    logic [MAG_W-1:0] quo_reg;

    logic [SEC_W:0]   trial;
    logic [SEC_W:0]   diff;
    logic             fits;

    // one restoring step per cycle: shift in the next dividend bit, try the subtract
    assign trial = {rem_reg, quo_reg[MAG_W-1]};
    assign diff  = trial - {1'b0, div_reg};
    assign fits  = trial >= {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            div_reg  <= '0;
            quo_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(MAG_W);
                rem_reg  <= '0;
                div_reg  <= divisor;
                quo_reg  <= dividend;
            end
            else if (busy_reg)
            begin
                rem_reg <= fits ? diff[SEC_W-1:0] : trial[SEC_W-1:0];
                quo_reg <= {quo_reg[MAG_W-2:0], fits};
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = quo_reg;
    assign rem_nz      = rem_reg != '0;

endmodule

`default_nettype wire

// ===== rtl/sliding_window_tile_diff_core.sv =====
`default_nettype none

// Sliding window tile difference.
// Input channel (in_valid/in_ready) takes one beat per centre position pos_x/pos_y
// in signed fixed point with FRAC_BITS fraction bits. For that beat the block
// emits on the output channel (out_valid/out_ready) an unload beat for every
// tile that left the tile window, then a load beat for every tile that entered
// it, at most MAX_RESULTS beats in all; last marks the final beat of the
// update. No beat at all is sent when the window does not change. Config
// port (cfg_valid/cfg_ready, cfg_index, cfg_data) sets the load reach
// (index 0) and the tile edge (index 1); write it only while idle.
// Sequence: the four window bounds go one after another through a shared
// restoring divider, one quotient bit per cycle. Then come the span clamp, a
// set-up for each strip (eight strips) and a step for each emitted tile,
// then a flush. in_ready is low for the whole update.
// The output register decouples the receiver: while it stalls, the tile walk
// holds with one tile parked in a look-ahead stage, no beat is lost.
// Reset empties the window (all bounds zero), sets the load reach to 0 and
// the tile edge to 1, and drops any beat in flight.

module sliding_window_tile_diff_core #(
    parameter int MAX_SPAN  = 4,
    parameter int FRAC_BITS = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [swtd_pkg::POS_W-1:0] pos_x,
    input  logic signed [swtd_pkg::POS_W-1:0] pos_y,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              action,
    output logic signed [swtd_pkg::TILE_W-1:0] tile_x,
    output logic signed [swtd_pkg::TILE_W-1:0] tile_y,
    output logic                              last,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [0:0]                        cfg_index,
    input  logic [swtd_pkg::RANGE_W-1:0]      cfg_data
);
    import swtd_pkg::*;

    // magnitude of the truncated whole part; |pos +- range| < 2^32
    localparam int MAG_W = POS_W - FRAC_BITS;
    localparam int EXT_W = POS_W + 2;
    localparam int QX_W  = POS_W + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_DIV,
        S_CLAMP,
        S_SETUP,
        S_SCAN,
        S_FLUSH
    } state_t;

    function automatic tile_t smin(tile_t a, tile_t b);
        return (a < b) ? a : b;
    endfunction

    function automatic tile_t smax(tile_t a, tile_t b);
        return (a > b) ? a : b;
    endfunction

    // ---------------------------------------------------------------------
    // registers
    // ---------------------------------------------------------------------
    state_t                   state_reg, state_next;
    logic [1:0]               idx_reg, idx_next;
    logic                     pass_reg, pass_next;
    logic [1:0]               strip_reg, strip_next;
    logic                     x_outer_reg, x_outer_next;
    tile_t                    outer_reg, outer_next;
    tile_t                    outer_hi_reg, outer_hi_next;
    tile_t                    inner_reg, inner_next;
    tile_t                    inner_lo_reg, inner_lo_next;
    tile_t                    inner_hi_reg, inner_hi_next;
    logic [RES_CNT_W-1:0]     cnt_reg, cnt_next;
    logic                     neg_reg, neg_next;
    logic signed [POS_W-1:0]  pos_x_reg, pos_x_next;
    logic signed [POS_W-1:0]  pos_y_reg, pos_y_next;
    logic [RANGE_W-1:0]       reach_reg, reach_next;
    logic [SEC_W-1:0]         tile_edge_reg, tile_edge_next;
    tile_t                    cur_bx_reg, cur_bx_next;
    tile_t                    cur_by_reg, cur_by_next;
    tile_t                    cur_ex_reg, cur_ex_next;
    tile_t                    cur_ey_reg, cur_ey_next;
    tile_t                    tgt_bx_reg, tgt_bx_next;
    tile_t                    tgt_by_reg, tgt_by_next;
    tile_t                    tgt_ex_reg, tgt_ex_next;
    tile_t                    tgt_ey_reg, tgt_ey_next;
    logic                     pend_valid_reg, pend_valid_next;
    action_t                  pend_action_reg, pend_action_next;
    tile_t                    pend_x_reg, pend_x_next;
    tile_t                    pend_y_reg, pend_y_next;
    logic                     out_valid_reg, out_valid_next;
    action_t                  action_reg, action_next;
    tile_t                    tile_x_reg, tile_x_next;
    tile_t                    tile_y_reg, tile_y_next;
    logic                     last_reg, last_next;

    // ---------------------------------------------------------------------
    // shared divider: floor(trunc(pos +- range) / tile edge) for each bound
    // ---------------------------------------------------------------------
    logic                     div_start;
    div_status_t              div_stat;
    logic [MAG_W-1:0]         div_quo;
    logic                     div_rem_nz;
    logic [MAG_W-1:0]         dividend;
    logic [SEC_W-1:0]         divisor;

    logic signed [POS_W-1:0]  sel_pos;
    logic [EXT_W-1:0]         pos_ext;
    logic [EXT_W-1:0]         rng_ext;
    logic [EXT_W-1:0]         sum;
    logic [EXT_W-1:0]         sum_abs;
    logic                     sum_neg;

    logic [QX_W-1:0]          q_ext;
    logic [QX_W-1:0]          q_up;
    tile_t                    bound;

    // even index is the begin (centre - range), odd the end (centre + range)
    assign sel_pos = idx_reg[1] ? pos_y_reg : pos_x_reg;
    assign pos_ext = {{(EXT_W-POS_W){sel_pos[POS_W-1]}}, sel_pos};
    assign rng_ext = {{(EXT_W-RANGE_W){1'b0}}, reach_reg};
    assign sum     = idx_reg[0] ? (pos_ext + rng_ext) : (pos_ext - rng_ext);
    assign sum_neg = sum[EXT_W-1];
    assign sum_abs = sum_neg ? (EXT_W'(0) - sum) : sum;
    // truncation toward zero works on the magnitude
    assign dividend = sum_abs[POS_W-1:FRAC_BITS];
    assign divisor  = (tile_edge_reg == '0) ? SEC_W'(1) : tile_edge_reg;

    swtd_div #(
        .MAG_W (MAG_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (divisor),
        .status   (div_stat),
        .quotient (div_quo),
        .rem_nz   (div_rem_nz)
    );

    // floor for negatives: round the magnitude up, then saturate to 24 bits
    assign q_ext = {{(QX_W-MAG_W){1'b0}}, div_quo};
    assign q_up  = q_ext + QX_W'(div_rem_nz);

    always_comb
    begin
        if (neg_reg)
        begin
            if (q_up > {{(QX_W-TILE_W){1'b0}}, TILE_MIN})
                bound = TILE_MIN;
            else
                bound = TILE_W'(TILE_W'(0) - q_up[TILE_W-1:0]);
        end
        else
        begin
            if (q_ext > {{(QX_W-TILE_W){1'b0}}, TILE_MAX})
                bound = TILE_MAX;
            else
                bound = q_ext[TILE_W-1:0];
        end
    end

    // ---------------------------------------------------------------------
    // window span clamp
    // ---------------------------------------------------------------------
    logic signed [TILE_W:0]   span_x;
    logic signed [TILE_W:0]   span_y;

    assign span_x = {tgt_ex_reg[TILE_W-1], tgt_ex_reg} - {tgt_bx_reg[TILE_W-1], tgt_bx_reg};
    assign span_y = {tgt_ey_reg[TILE_W-1], tgt_ey_reg} - {tgt_by_reg[TILE_W-1], tgt_by_reg};

    // ---------------------------------------------------------------------
    // strip bounds: unload pass walks current minus target, load pass the reverse
    // ---------------------------------------------------------------------
    tile_t abx, aby, aex, aey, bbx, bby, bex, bey;
    tile_t o_lo, o_hi, i_lo, i_hi;
    logic  o_x;
    logic  strip_live;
    logic  last_strip;

    assign abx = pass_reg ? tgt_bx_reg : cur_bx_reg;
    assign aby = pass_reg ? tgt_by_reg : cur_by_reg;
    assign aex = pass_reg ? tgt_ex_reg : cur_ex_reg;
    assign aey = pass_reg ? tgt_ey_reg : cur_ey_reg;
    assign bbx = pass_reg ? cur_bx_reg : tgt_bx_reg;
    assign bby = pass_reg ? cur_by_reg : tgt_by_reg;
    assign bex = pass_reg ? cur_ex_reg : tgt_ex_reg;
    assign bey = pass_reg ? cur_ey_reg : tgt_ey_reg;

    always_comb
    begin
        case (strip_reg)
            2'd0:
            begin
                // left strip, x outer
                o_lo = abx;
                o_hi = smin(aex, bbx);
                i_lo = aby;
                i_hi = aey;
                o_x  = 1'b1;
            end
            2'd1:
            begin
                // right strip, x outer
                o_lo = smax(bex, abx);
                o_hi = aex;
                i_lo = aby;
                i_hi = aey;
                o_x  = 1'b1;
            end
            2'd2:
            begin
                // top strip, y outer over the x overlap
                o_lo = aby;
                o_hi = smin(aey, bby);
                i_lo = smax(abx, bbx);
                i_hi = smin(aex, bex);
                o_x  = 1'b0;
            end
            default:
            begin
                // bottom strip, y outer over the x overlap
                o_lo = smax(bey, aby);
                o_hi = aey;
                i_lo = smax(abx, bbx);
                i_hi = smin(aex, bex);
                o_x  = 1'b0;
            end
        endcase
    end

    assign strip_live = (o_lo < o_hi) && (i_lo < i_hi);
    assign last_strip = pass_reg && (strip_reg == 2'd3);

    // ---------------------------------------------------------------------
    // tile walk step
    // ---------------------------------------------------------------------
    logic signed [TILE_W:0]   inner_inc;
    logic signed [TILE_W:0]   outer_inc;
    logic                     inner_more;
    logic                     outer_more;
    tile_t                    walk_x;
    tile_t                    walk_y;
    logic                     slot_free;
    logic                     walk_go;

    assign inner_inc  = {inner_reg[TILE_W-1], inner_reg} + (TILE_W+1)'(1);
    assign outer_inc  = {outer_reg[TILE_W-1], outer_reg} + (TILE_W+1)'(1);
    assign inner_more = inner_inc < $signed({inner_hi_reg[TILE_W-1], inner_hi_reg});
    assign outer_more = outer_inc < $signed({outer_hi_reg[TILE_W-1], outer_hi_reg});
    assign walk_x     = x_outer_reg ? outer_reg : inner_reg;
    assign walk_y     = x_outer_reg ? inner_reg : outer_reg;
    assign slot_free  = !out_valid_reg || out_ready;
    // the look-ahead stage only moves on when the output register can take it
    assign walk_go    = !pend_valid_reg || slot_free;

    // ---------------------------------------------------------------------
    // next state
    // ---------------------------------------------------------------------
    always_comb
    begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        pass_next        = pass_reg;
        strip_next       = strip_reg;
        x_outer_next     = x_outer_reg;
        outer_next       = outer_reg;
        outer_hi_next    = outer_hi_reg;
        inner_next       = inner_reg;
        inner_lo_next    = inner_lo_reg;
        inner_hi_next    = inner_hi_reg;
        cnt_next         = cnt_reg;
        neg_next         = neg_reg;
        pos_x_next       = pos_x_reg;
        pos_y_next       = pos_y_reg;
        reach_next       = reach_reg;
        tile_edge_next   = tile_edge_reg;
        cur_bx_next      = cur_bx_reg;
        cur_by_next      = cur_by_reg;
        cur_ex_next      = cur_ex_reg;
        cur_ey_next      = cur_ey_reg;
        tgt_bx_next      = tgt_bx_reg;
        tgt_by_next      = tgt_by_reg;
        tgt_ex_next      = tgt_ex_reg;
        tgt_ey_next      = tgt_ey_reg;
        pend_valid_next  = pend_valid_reg;
        pend_action_next = pend_action_reg;
        pend_x_next      = pend_x_reg;
        pend_y_next      = pend_y_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        action_next      = action_reg;
        tile_x_next      = tile_x_reg;
        tile_y_next      = tile_y_reg;
        last_next        = last_reg;
        div_start        = 1'b0;

        if (cfg_valid)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_REACH:     reach_next     = cfg_data;
                CFG_TILE_EDGE: tile_edge_next = cfg_data[SEC_W-1:0];
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    pos_x_next = pos_x;
                    pos_y_next = pos_y;
                    idx_next   = 2'd0;
                    state_next = S_PREP;
                end
            end

            S_PREP:
            begin
                div_start  = 1'b1;
                neg_next   = sum_neg;
                state_next = S_DIV;
            end

            S_DIV:
            begin
                if (div_stat.done)
                begin
                    case (idx_reg)
                        2'd0:    tgt_bx_next = bound;
                        2'd1:    tgt_ex_next = bound;
                        2'd2:    tgt_by_next = bound;
                        default: tgt_ey_next = bound;
                    endcase
                    if (idx_reg == 2'd3)
                        state_next = S_CLAMP;
                    else
                    begin
                        idx_next   = idx_reg + 2'd1;
                        state_next = S_PREP;
                    end
                end
            end

            S_CLAMP:
            begin
                // keep the begin, pull the end in
                if (span_x > (TILE_W+1)'(MAX_SPAN))
                    tgt_ex_next = tgt_bx_reg + TILE_W'(MAX_SPAN);
                if (span_y > (TILE_W+1)'(MAX_SPAN))
                    tgt_ey_next = tgt_by_reg + TILE_W'(MAX_SPAN);
                pass_next  = 1'b0;
                strip_next = 2'd0;
                cnt_next   = '0;
                state_next = S_SETUP;
            end

            S_SETUP:
            begin
                if (strip_live)
                begin
                    outer_next    = o_lo;
                    outer_hi_next = o_hi;
                    inner_next    = i_lo;
                    inner_lo_next = i_lo;
                    inner_hi_next = i_hi;
                    x_outer_next  = o_x;
                    state_next    = S_SCAN;
                end
                else if (last_strip)
                    state_next = S_FLUSH;
                else
                    {pass_next, strip_next} = {pass_reg, strip_reg} + 3'd1;
            end

            S_SCAN:
            begin
                if (walk_go)
                begin
                    if (pend_valid_reg)
                    begin
                        out_valid_next = 1'b1;
                        action_next    = pend_action_reg;
                        tile_x_next    = pend_x_reg;
                        tile_y_next    = pend_y_reg;
                        last_next      = 1'b0;
                    end
                    pend_valid_next  = 1'b1;
                    pend_action_next = pass_reg ? ACT_LOAD : ACT_UNLOAD;
                    pend_x_next      = walk_x;
                    pend_y_next      = walk_y;
                    cnt_next         = cnt_reg + RES_CNT_W'(1);

                    // stop at the result cap, else advance inner, outer, strip
                    if (cnt_reg == RES_CNT_W'(MAX_RESULTS - 1))
                        state_next = S_FLUSH;
                    else if (inner_more)
                        inner_next = inner_inc[TILE_W-1:0];
                    else if (outer_more)
                    begin
                        outer_next = outer_inc[TILE_W-1:0];
                        inner_next = inner_lo_reg;
                    end
                    else if (last_strip)
                        state_next = S_FLUSH;
                    else
                    begin
                        {pass_next, strip_next} = {pass_reg, strip_reg} + 3'd1;
                        state_next = S_SETUP;
                    end
                end
            end

            S_FLUSH:
            begin
                if (!pend_valid_reg || slot_free)
                begin
                    if (pend_valid_reg)
                    begin
                        out_valid_next  = 1'b1;
                        action_next     = pend_action_reg;
                        tile_x_next     = pend_x_reg;
                        tile_y_next     = pend_y_reg;
                        last_next       = 1'b1;
                        pend_valid_next = 1'b0;
                    end
                    cur_bx_next = tgt_bx_reg;
                    cur_by_next = tgt_by_reg;
                    cur_ex_next = tgt_ex_reg;
                    cur_ey_next = tgt_ey_reg;
                    state_next  = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------------
    // state and registered outputs
    // ---------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            idx_reg         <= '0;
            pass_reg        <= 1'b0;
            strip_reg       <= '0;
            x_outer_reg     <= 1'b0;
            outer_reg       <= '0;
            outer_hi_reg    <= '0;
            inner_reg       <= '0;
            inner_lo_reg    <= '0;
            inner_hi_reg    <= '0;
            cnt_reg         <= '0;
            neg_reg         <= 1'b0;
            pos_x_reg       <= '0;
            pos_y_reg       <= '0;
            reach_reg       <= '0;
            tile_edge_reg   <= SEC_W'(1);
            cur_bx_reg      <= '0;
            cur_by_reg      <= '0;
            cur_ex_reg      <= '0;
            cur_ey_reg      <= '0;
            tgt_bx_reg      <= '0;
            tgt_by_reg      <= '0;
            tgt_ex_reg      <= '0;
            tgt_ey_reg      <= '0;
            pend_valid_reg  <= 1'b0;
            pend_action_reg <= ACT_UNLOAD;
            pend_x_reg      <= '0;
            pend_y_reg      <= '0;
            out_valid_reg   <= 1'b0;
            action_reg      <= ACT_UNLOAD;
            tile_x_reg      <= '0;
            tile_y_reg      <= '0;
            last_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            idx_reg         <= idx_next;
            pass_reg        <= pass_next;
            strip_reg       <= strip_next;
            x_outer_reg     <= x_outer_next;
            outer_reg       <= outer_next;
            outer_hi_reg    <= outer_hi_next;
            inner_reg       <= inner_next;
            inner_lo_reg    <= inner_lo_next;
            inner_hi_reg    <= inner_hi_next;
            cnt_reg         <= cnt_next;
            neg_reg         <= neg_next;
            pos_x_reg       <= pos_x_next;
            pos_y_reg       <= pos_y_next;
            reach_reg       <= reach_next;
            tile_edge_reg   <= tile_edge_next;
            cur_bx_reg      <= cur_bx_next;
            cur_by_reg      <= cur_by_next;
            cur_ex_reg      <= cur_ex_next;
            cur_ey_reg      <= cur_ey_next;
            tgt_bx_reg      <= tgt_bx_next;
            tgt_by_reg      <= tgt_by_next;
            tgt_ex_reg      <= tgt_ex_next;
            tgt_ey_reg      <= tgt_ey_next;
            pend_valid_reg  <= pend_valid_next;
            pend_action_reg <= pend_action_next;
            pend_x_reg      <= pend_x_next;
            pend_y_reg      <= pend_y_next;
            out_valid_reg   <= out_valid_next;
            action_reg      <= action_next;
            tile_x_reg      <= tile_x_next;
            tile_y_reg      <= tile_y_next;
            last_reg        <= last_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign action    = action_reg;
    assign tile_x    = tile_x_reg;
    assign tile_y    = tile_y_reg;
    assign last      = last_reg;

    // ---------------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------------
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input accepted again while an update is running");

    a_no_pending_during_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.busy |-> !pend_valid_reg)
        else $error("look-ahead tile left over while bounds are computed");

    a_walk_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> ((outer_reg < outer_hi_reg) && (inner_reg < inner_hi_reg)))
        else $error("tile walk outside its strip");

endmodule

`default_nettype wire
